/* hdl/dpm_pkg.sv */
// Shared constants, types and elaboration-time table builders for the
// Magnus dew point pipeline. No dependencies.
package dpm_pkg;

  // Fraction bits of the wide log accumulator.
  localparam int LN_Q     = 58;
  localparam int TEMP_W   = 15;
  localparam int HUM_W    = 14;
  localparam int DEW_W    = 15;
  // Highest bit position of a humidity reading.
  localparam int HUM_MSB  = HUM_W - 1;
  // Zero bits below the normalized humidity mantissa.
  localparam int MANT_PAD = LN_Q + 1 - HUM_W;

  // Magnus constants in hundredths (B_SCALED in ten-thousandths).
  localparam int A_CENTI     = 1762;
  localparam int B_CENTI     = 24312;
  localparam int B_SCALED    = 2431200;
  localparam int DEN_A_SCALE = 100;
  localparam int DEN_A_HALF  = 50;
  localparam int DEW_LIMIT   = 10000;
  localparam int HUM_FULL    = 10000;

  // Width of b+T times 100 and quotient width of the dew point divide.
  localparam int DEN_A_W = 22;
  localparam int QUO_B_W = 15;

  typedef logic [63:0]        q58_t;
  typedef logic [13:0][63:0]  ln2_tab_t;

  // Unsigned 64-bit quotient by shift and subtract, for table building only.
  function automatic q58_t udiv64(q58_t num, q58_t den);
    q58_t        quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1 + 2^-k) in Q58 from the alternating series.
  function automatic q58_t ln_tab(int k);
    q58_t s;
    q58_t term;
    int   n;
    s = '0;
    for (n = 1; n * k <= LN_Q; n++) begin
      term = udiv64(64'd1 << (LN_Q - n * k), 64'(n));
      if (n[0] == 1'b1) begin
        s = s + term;
      end else begin
        s = s - term;
      end
    end
    return s;
  endfunction

  // ln 2 in Q58 as 2*atanh(1/3).
  function automatic q58_t ln2_q();
    q58_t two;
    q58_t p3;
    q58_t sum;
    q58_t q;
    int   n;
    logic done;
    two  = 64'd1 << (LN_Q + 1);
    p3   = 64'd3;
    sum  = '0;
    done = 1'b0;
    for (n = 1; n < 80; n += 2) begin
      if (!done) begin
        q = udiv64(two, p3);
        if (q == 64'd0) begin
          done = 1'b1;
        end else begin
          sum = sum + udiv64(q, 64'(n));
          if (p3 > (64'd1 << 59)) begin
            done = 1'b1;
          end else begin
            p3 = p3 * 64'd9;
          end
        end
      end
    end
    return sum;
  endfunction

  // p * ln 2 for every exponent of a humidity reading.
  function automatic ln2_tab_t ln2_table();
    ln2_tab_t t;
    q58_t     l2;
    int       p;
    l2 = ln2_q();
    for (p = 0; p < 14; p++) begin
      t[p] = 64'(p) * l2;
    end
    return t;
  endfunction

  // Shift-add log of a constant integer, same steps as the cell chain.
  function automatic q58_t ln_int_c(int unsigned v, int fb);
    int   p;
    int   k;
    q58_t m;
    q58_t z;
    q58_t c;
    q58_t y;
    p = 0;
    while (p < HUM_MSB && (v >> (p + 1)) != 0) begin
      p++;
    end
    m = 64'(v) << (LN_Q - p);
    z = 64'd1 << LN_Q;
    y = '0;
    for (k = 1; k <= fb; k++) begin
      c = z + (z >> k);
      if (c <= m) begin
        z = c;
        y = y + ln_tab(k);
      end
    end
    return 64'(p) * ln2_q() + y;
  endfunction

endpackage

/* hdl/dew_point_magnus.sv */
// Throughput: one beat per cycle while stall_o is low. The pipeline depth is
// set by the chain of FRAC_BITS log cells and the two restoring divider
// chains (FRAC_BITS + 6 and 15 cells, one quotient bit per cell).
// Reset clears the stage valid bits and the output/skid flags only.
// Top level: Magnus dew point pipeline. Uses dpm_pkg, dpm_ln_cell, dpm_div_cell.
module dew_point_magnus
  import dpm_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic signed [TEMP_W-1:0] temperature_centi_i,
  input  logic                     temperature_ok_i,
  input  logic [HUM_W-1:0]         humidity_centi_i,
  input  logic                     humidity_ok_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [DEW_W-1:0]  dew_point_centi_o,
  output logic                     dew_point_ok_o
);

  // Stage layout
  localparam int QA  = FRAC_BITS + 6;
  localparam int NAW = FRAC_BITS + 26;
  localparam int QB  = QUO_B_W;
  localparam int DBW = FRAC_BITS + 13;
  localparam int NBW = FRAC_BITS + 28;
  localparam int GW  = FRAC_BITS + 8;
  localparam int NMW = GW + 23;
  localparam int DBX = FRAC_BITS + 15;
  localparam int NS  = QA + 3 + QB + 1;
  localparam int Shf = LN_Q - FRAC_BITS;

  localparam q58_t     Ln10k  = ln_int_c(HUM_FULL, FRAC_BITS);
  localparam ln2_tab_t Ln2Tab = ln2_table();
  localparam q58_t     Half   = 64'd1 << (Shf - 1);
  localparam q58_t     ZOne   = 64'd1 << LN_Q;
  localparam logic signed [DBX-1:0] DenBase = DBX'(longint'(A_CENTI) << FRAC_BITS);

  logic en;

  // ---------------- input stage ----------------
  logic                     tneg;
  logic [TEMP_W-1:0]        t_abs;
  logic [24:0]              mul_a;
  logic signed [16:0]       bt_s;
  logic [15:0]              bt_u;
  logic [DEN_A_W-1:0]       den_a;
  logic [NAW-1:0]           na_d;
  logic [3:0]               p_d;
  logic [HUM_W-1:0]         mn_d;
  logic                     ok_d;

  always_comb begin
    tneg  = temperature_centi_i[TEMP_W-1];
    t_abs = tneg ? (TEMP_W'(0) - temperature_centi_i) : temperature_centi_i;
    mul_a = 25'(t_abs) * 25'(A_CENTI);
    bt_s  = 17'(B_CENTI) + 17'(temperature_centi_i);
    bt_u  = bt_s[15:0];
    den_a = DEN_A_W'(bt_u) * DEN_A_W'(DEN_A_SCALE);
    na_d  = NAW'({mul_a, {FRAC_BITS{1'b0}}}) + NAW'(DEN_A_W'(bt_u) * DEN_A_W'(DEN_A_HALF));
    ok_d  = temperature_ok_i & humidity_ok_i & (humidity_centi_i != '0);
  end

  // Find the leading one of the humidity and normalize it
  always_comb begin
    p_d = '0;
    for (int i = 1; i < HUM_W; i++) begin
      if (humidity_centi_i[i]) begin
        p_d = 4'(i);
      end
    end
    mn_d = humidity_centi_i << (4'(HUM_MSB) - p_d);
  end

  logic [NAW-1:0]     na_q;
  logic [DEN_A_W-1:0] da_q;
  logic [HUM_W-1:0]   mn0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      na_q  <= na_d;
      da_q  <= den_a;
      mn0_q <= mn_d;
    end
  end

  // ---------------- sideband lines ----------------
  logic       vld_q  [NS];
  logic       ok_q   [NS];
  logic       tneg_q [QA+1];
  logic [3:0] p_q    [FRAC_BITS+1];
  logic       nsg_q  [QB+1];
  logic       nsg_d;

  // Shift valid bits down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NS; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Carry flags and exponent alongside the data
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q[0]   <= ok_d;
      tneg_q[0] <= tneg;
      p_q[0]    <= p_d;
      nsg_q[0]  <= nsg_d;
      for (int i = 1; i < NS; i++) begin
        ok_q[i] <= ok_q[i-1];
      end
      for (int i = 1; i <= QA; i++) begin
        tneg_q[i] <= tneg_q[i-1];
      end
      for (int i = 1; i <= FRAC_BITS; i++) begin
        p_q[i] <= p_q[i-1];
      end
      for (int i = 1; i <= QB; i++) begin
        nsg_q[i] <= nsg_q[i-1];
      end
    end
  end

  // ---------------- log cell chain ----------------
  logic [LN_Q:0]    z_w  [FRAC_BITS+1];
  logic [LN_Q:0]    y_w  [FRAC_BITS+1];
  logic [HUM_W-1:0] mn_w [FRAC_BITS+1];

  assign z_w[0]  = ZOne[LN_Q:0];
  assign y_w[0]  = '0;
  assign mn_w[0] = mn0_q;

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_ln
    dpm_ln_cell #(
      .K (k)
    ) u_ln (
      .clk_i (clk_i),
      .en_i  (en),
      .z_i   (z_w[k-1]),
      .y_i   (y_w[k-1]),
      .mn_i  (mn_w[k-1]),
      .z_o   (z_w[k]),
      .y_o   (y_w[k]),
      .mn_o  (mn_w[k])
    );
  end

  // ---------------- a*T/(b+T) divider chain ----------------
  logic [DEN_A_W-1:0] ra_w  [QA+1];
  logic [QA-1:0]      qa_w  [QA+1];
  logic [DEN_A_W-1:0] dda_w [QA+1];

  assign ra_w[0]  = DEN_A_W'(na_q[NAW-1:QA]);
  assign qa_w[0]  = na_q[QA-1:0];
  assign dda_w[0] = da_q;

  for (genvar j = 0; j < QA; j++) begin : g_diva
    dpm_div_cell #(
      .DEN_W (DEN_A_W),
      .QUO_W (QA)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .r_i   (ra_w[j]),
      .nq_i  (qa_w[j]),
      .d_i   (dda_w[j]),
      .r_o   (ra_w[j+1]),
      .nq_o  (qa_w[j+1]),
      .d_o   (dda_w[j+1])
    );
  end

  // ---------------- log finish: scale, round, align ----------------
  logic signed [63:0]   lnv_d, lnv_q;
  logic [63:0]          lmag_d, lmag_q;
  logic                 lsg_q, lsg2_q;
  logic [63:0]          lsum;
  logic [GW-1:0]        lrnd_d, lrnd_q;
  logic signed [GW-1:0] lnq_d, lnq_q, lnq_p1_q, lnq_p2_q;

  always_comb begin
    lnv_d  = $signed(Ln2Tab[p_q[FRAC_BITS]] + 64'(y_w[FRAC_BITS]) - Ln10k);
    lmag_d = lnv_q[63] ? (64'd0 - lnv_q) : lnv_q;
    lsum   = lmag_q + Half;
    lrnd_d = GW'(lsum >> Shf);
    lnq_d  = lsg2_q ? -$signed(lrnd_q) : $signed(lrnd_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lnv_q    <= lnv_d;
      lmag_q   <= lmag_d;
      lsg_q    <= lnv_q[63];
      lrnd_q   <= lrnd_d;
      lsg2_q   <= lsg_q;
      lnq_q    <= lnq_d;
      lnq_p1_q <= lnq_q;
      lnq_p2_q <= lnq_p1_q;
    end
  end

  // ---------------- gamma and dew point operands ----------------
  logic signed [GW-1:0]  qa_s;
  logic signed [GW-1:0]  gq_d, gq_q;
  logic signed [NMW-1:0] numb_d, numb_q;
  logic signed [DBX-1:0] denx;
  logic [DBW-1:0]        denb_q;
  logic [NMW-1:0]        nmag;
  logic [NBW-1:0]        nb_d, nb_q;
  logic [DBW-1:0]        db_q;

  always_comb begin
    qa_s   = $signed(GW'(qa_w[QA]));
    gq_d   = tneg_q[QA] ? (lnq_p2_q - qa_s) : (lnq_p2_q + qa_s);
    numb_d = NMW'(gq_q) * NMW'(B_SCALED);
    denx   = DenBase - DBX'(gq_q) * DBX'(DEN_A_SCALE);
    nsg_d  = numb_q[NMW-1];
    nmag   = nsg_d ? (NMW'(0) - numb_q) : numb_q;
    nb_d   = NBW'(nmag) + NBW'(denb_q >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gq_q   <= gq_d;
      numb_q <= numb_d;
      denb_q <= denx[DBW-1:0];
      nb_q   <= nb_d;
      db_q   <= denb_q;
    end
  end

  // ---------------- dew point divider chain ----------------
  logic [DBW-1:0] rb_w  [QB+1];
  logic [QB-1:0]  qb_w  [QB+1];
  logic [DBW-1:0] ddb_w [QB+1];

  assign rb_w[0]  = nb_q[NBW-1:QB];
  assign qb_w[0]  = nb_q[QB-1:0];
  assign ddb_w[0] = db_q;

  for (genvar j = 0; j < QB; j++) begin : g_divb
    dpm_div_cell #(
      .DEN_W (DBW),
      .QUO_W (QB)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .r_i   (rb_w[j]),
      .nq_i  (qb_w[j]),
      .d_i   (ddb_w[j]),
      .r_o   (rb_w[j+1]),
      .nq_o  (qb_w[j+1]),
      .d_o   (ddb_w[j+1])
    );
  end

  // ---------------- saturate, sign, mask ----------------
  logic [DEW_W-1:0] dmag;
  logic [DEW_W-1:0] res;
  logic             res_ok;
  logic             last_v;

  always_comb begin
    dmag   = (qb_w[QB] > DEW_W'(DEW_LIMIT)) ? DEW_W'(DEW_LIMIT) : qb_w[QB];
    res_ok = ok_q[NS-1];
    if (!res_ok) begin
      res = '0;
    end else if (nsg_q[QB]) begin
      res = DEW_W'(0) - dmag;
    end else begin
      res = dmag;
    end
    last_v = vld_q[NS-1];
  end

  // ---------------- output register and skid ----------------
  logic             out_v_q, skid_v_q;
  logic [DEW_W-1:0] out_d_q, skid_d_q;
  logic             out_ok_q, skid_ok_q;
  logic             from_skid, out_load, skid_load;

  assign en        = !skid_v_q;
  assign stall_o   = skid_v_q;
  assign from_skid = skid_v_q && !stall_i;
  assign out_load  = !skid_v_q && (!out_v_q || !stall_i);
  assign skid_load = !skid_v_q && out_v_q && stall_i && last_v;

  // Track output and skid occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (from_skid) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else if (out_load) begin
        out_v_q <= last_v;
      end else if (skid_load) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  // Move the result beat
  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_d_q  <= skid_d_q;
      out_ok_q <= skid_ok_q;
    end else if (out_load) begin
      out_d_q  <= res;
      out_ok_q <= res_ok;
    end
    if (skid_load) begin
      skid_d_q  <= res;
      skid_ok_q <= res_ok;
    end
  end

  assign valid_o           = out_v_q;
  assign dew_point_centi_o = $signed(out_d_q);
  assign dew_point_ok_o    = out_ok_q;

endmodule

/* hdl/dpm_ln_cell.sv */
// One step of the shift-add logarithm: try the factor (1 + 2^-K).
// Depends on dpm_pkg for the Q58 log table.
module dpm_ln_cell
  import dpm_pkg::*;
#(
  parameter int K = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [LN_Q:0]     z_i,
  input  logic [LN_Q:0]     y_i,
  input  logic [HUM_W-1:0]  mn_i,
  output logic [LN_Q:0]     z_o,
  output logic [LN_Q:0]     y_o,
  output logic [HUM_W-1:0]  mn_o
);

  localparam q58_t TabK = ln_tab(K);

  logic [LN_Q+1:0] cand;
  logic [LN_Q:0]   mant;
  logic            take;
  logic [LN_Q:0]   z_d;
  logic [LN_Q:0]   y_d;

  // Grow the product if it stays at or below the mantissa
  always_comb begin
    mant = {mn_i, {MANT_PAD{1'b0}}};
    cand = {1'b0, z_i} + {1'b0, z_i >> K};
    take = (cand <= {1'b0, mant});
    z_d  = take ? cand[LN_Q:0] : z_i;
    y_d  = take ? (y_i + TabK[LN_Q:0]) : y_i;
  end

  // Advance with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_o  <= z_d;
      y_o  <= y_d;
      mn_o <= mn_i;
    end
  end

endmodule

/* hdl/dpm_div_cell.sv */
// One restoring division step: one quotient bit per cell.
// No package dependencies.
module dpm_div_cell #(
  parameter int DEN_W = 22,
  parameter int QUO_W = 26
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] r_i,
  input  logic [QUO_W-1:0] nq_i,
  input  logic [DEN_W-1:0] d_i,
  output logic [DEN_W-1:0] r_o,
  output logic [QUO_W-1:0] nq_o,
  output logic [DEN_W-1:0] d_o
);

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] r_d;
  logic [QUO_W-1:0] nq_d;

  // Bring down the next dividend bit, subtract when it fits
  always_comb begin
    trial = {r_i, nq_i[QUO_W-1]};
    diff  = trial - {1'b0, d_i};
    ge    = (trial >= {1'b0, d_i});
    r_d   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    nq_d  = {nq_i[QUO_W-2:0], ge};
  end

  // Advance with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o  <= r_d;
      nq_o <= nq_d;
      d_o  <= d_i;
    end
  end

endmodule

/* hdl/dpm_checker.sv */
// Port-level checks for the dew point pipeline, bound to the top level.
// Depends on dpm_pkg for field widths.
module dpm_checker
  import dpm_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     valid_i,
  input logic                     stall_o,
  input logic signed [TEMP_W-1:0] temperature_centi_i,
  input logic                     temperature_ok_i,
  input logic [HUM_W-1:0]         humidity_centi_i,
  input logic                     humidity_ok_i,
  input logic                     valid_o,
  input logic                     stall_i,
  input logic signed [DEW_W-1:0]  dew_point_centi_o,
  input logic                     dew_point_ok_o
);

  // An invalid result carries a zero dew point
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !dew_point_ok_o |-> dew_point_centi_o == '0)
    else $error("invalid dew point beat is not zero");

  // A valid result stays inside the saturation range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && dew_point_ok_o |->
      dew_point_centi_o >= -DEW_W'(DEW_LIMIT) && dew_point_centi_o <= DEW_W'(DEW_LIMIT))
    else $error("dew point outside saturation range");

  // Input stall only rises after an output beat was held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_o && stall_i))
    else $error("input stalled without a held output beat");

  // A held output beat keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(dew_point_centi_o) && $stable(dew_point_ok_o))
    else $error("held output beat changed");

endmodule

bind dew_point_magnus dpm_checker u_dpm_checker (.*);
